### hw/rtl/priority_tone_alert_sequencer_top_defines.svh
// Assertion macros used by the checker file of the alert sequencer.
`ifndef PRIORITY_TONE_ALERT_SEQUENCER_TOP_DEFINES_SVH
`define PRIORITY_TONE_ALERT_SEQUENCER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is held
`define PTAS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also checks across reset
`define PTAS_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/ptas_pkg.sv
`timescale 1ns / 1ps

package ptas_pkg;

    // Sizes
    localparam int MAX_NOTES   = 4;
    localparam int TIME_W      = 48;
    localparam int TONE_W      = 13;
    localparam int IN_W        = 16;
    localparam int ID_W        = 5;
    localparam int POS_W       = 3;
    localparam int US_PER_MS   = 1000;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    // Opcodes
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_NOTIFY      = 2'd1;
    localparam logic [1:0] OP_PLAY_CUSTOM = 2'd2;
    localparam logic [1:0] OP_STOP_CUSTOM = 2'd3;

    localparam logic [ID_W-1:0]   NO_ALERT = 5'd16;
    localparam logic [TONE_W-1:0] FREQ_MIN = 13'd100;
    localparam logic [TONE_W-1:0] FREQ_MAX = 13'd5000;
    localparam logic [TONE_W-1:0] LEN_MIN  = 13'd1;
    localparam logic [TONE_W-1:0] LEN_MAX  = 13'd5000;

    typedef struct packed {
        logic [TONE_W-1:0] hz;
        logic [TONE_W-1:0] ms;
        logic [TONE_W-1:0] gap;
    } note_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   alert_id;
        logic [IN_W-1:0]   custom_freq;
        logic [IN_W-1:0]   custom_len;
        logic [TIME_W-1:0] now_time;
    } item_t;

    typedef struct packed {
        logic              stop_cmd;
        logic              start_cmd;
        logic [TONE_W-1:0] tone_freq;
        logic [TONE_W-1:0] tone_len;
        logic [ID_W-1:0]   playing_alert;
    } result_t;

    typedef struct packed {
        logic [15:0]       pending_mask;
        logic [ID_W-1:0]   active_alert;
        logic [POS_W-1:0]  note_pos;
        logic              tone_on;
        logic [TIME_W-1:0] deadline;
        logic [TONE_W-1:0] req_freq;
        logic [TONE_W-1:0] req_len;
        logic [TONE_W-1:0] lat_freq;
        logic [TONE_W-1:0] lat_len;
    } state_t;

    // Note patterns: frequency Hz, duration ms, gap ms (alert 0 is the custom tone)
    localparam note_t NOTE_ROM [0:15][0:3] = '{
        '{'{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd650, 13'd70, 13'd50}, '{13'd900, 13'd70, 13'd50},
          '{13'd1200, 13'd100, 13'd0}, '{13'd0, 13'd0, 13'd0}},
        '{'{13'd700, 13'd90, 13'd50}, '{13'd1100, 13'd130, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd1100, 13'd90, 13'd50}, '{13'd650, 13'd150, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd750, 13'd60, 13'd40}, '{13'd1000, 13'd80, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd550, 13'd70, 13'd40}, '{13'd900, 13'd100, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd850, 13'd60, 13'd35}, '{13'd1150, 13'd90, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd600, 13'd70, 13'd40}, '{13'd850, 13'd70, 13'd40},
          '{13'd1150, 13'd100, 13'd0}, '{13'd0, 13'd0, 13'd0}},
        '{'{13'd520, 13'd140, 13'd100}, '{13'd520, 13'd140, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd780, 13'd100, 13'd80}, '{13'd780, 13'd100, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd280, 13'd180, 13'd80}, '{13'd280, 13'd180, 13'd80},
          '{13'd280, 13'd260, 13'd0}, '{13'd0, 13'd0, 13'd0}},
        '{'{13'd950, 13'd70, 13'd70}, '{13'd950, 13'd70, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd450, 13'd180, 13'd100}, '{13'd450, 13'd180, 13'd100},
          '{13'd450, 13'd180, 13'd0}, '{13'd0, 13'd0, 13'd0}},
        '{'{13'd400, 13'd300, 13'd150}, '{13'd400, 13'd300, 13'd0},
          '{13'd0, 13'd0, 13'd0},     '{13'd0, 13'd0, 13'd0}},
        '{'{13'd330, 13'd260, 13'd100}, '{13'd330, 13'd260, 13'd100},
          '{13'd330, 13'd260, 13'd0}, '{13'd0, 13'd0, 13'd0}},
        '{'{13'd1250, 13'd70, 13'd45}, '{13'd1250, 13'd70, 13'd45},
          '{13'd1250, 13'd70, 13'd45}, '{13'd1250, 13'd140, 13'd0}}
    };

    localparam logic [POS_W-1:0] NOTE_COUNT [0:15] = '{
        3'd1, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3,
        3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4
    };

    // Notes in a pattern, limited to MAX_NOTES
    function automatic logic [POS_W-1:0] pattern_len(input logic [3:0] a);
        logic [POS_W-1:0] n;
        n = NOTE_COUNT[a];
        if (int'(n) < MAX_NOTES) begin
            return n;
        end
        return POS_W'(MAX_NOTES);
    endfunction

    // Clamp a 16-bit request value into [lo, hi]
    function automatic logic [TONE_W-1:0] clamp_val(input logic [IN_W-1:0] v,
                                                   input logic [TONE_W-1:0] lo,
                                                   input logic [TONE_W-1:0] hi);
        if (v < IN_W'(lo)) begin
            return lo;
        end
        if (v > IN_W'(hi)) begin
            return hi;
        end
        return v[TONE_W-1:0];
    endfunction

endpackage

### hw/rtl/ptas_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one request
module ptas_step import ptas_pkg::*; (
    input  state_t  cur,
    input  item_t   item,
    output state_t  nxt,
    output result_t res
);

    logic [ID_W-1:0]   top_pend;
    logic              preempt;
    logic [15:0]       mask1;
    logic [ID_W-1:0]   act1;
    logic [POS_W-1:0]  pos1;
    logic [POS_W-1:0]  pos2;
    logic              ton1;
    logic [TIME_W-1:0] dl1;
    logic [TONE_W-1:0] lat_f1;
    logic [TONE_W-1:0] lat_l1;
    logic [POS_W-1:0]  plen;
    note_t             note;
    logic [TONE_W-1:0] dly_ms;
    logic [22:0]       dly_us;
    logic [TIME_W-1:0] dl_add;

    // Highest pending alert, NO_ALERT when the mask is empty
    always_comb begin
        top_pend = NO_ALERT;
        for (int i = 0; i < 16; i++) begin
            if (cur.pending_mask[i]) begin
                top_pend = ID_W'(i);
            end
        end
    end

    assign preempt = (top_pend != NO_ALERT)
                   && ((cur.active_alert == NO_ALERT) || (top_pend > cur.active_alert));

    // State after a possible preemption on tick
    always_comb begin
        mask1  = cur.pending_mask;
        act1   = cur.active_alert;
        pos1   = cur.note_pos;
        ton1   = cur.tone_on;
        dl1    = cur.deadline;
        lat_f1 = cur.lat_freq;
        lat_l1 = cur.lat_len;
        if (preempt) begin
            mask1[top_pend[3:0]] = 1'b0;
            act1   = top_pend;
            pos1   = '0;
            ton1   = 1'b0;
            dl1    = item.now_time;
            lat_f1 = cur.req_freq;
            lat_l1 = cur.req_len;
        end
    end

    // Current note lookup; the custom alert uses the latched values
    always_comb begin
        note = NOTE_ROM[act1[3:0]][pos1[1:0]];
        if (act1[3:0] == 4'd0) begin
            note.hz  = lat_f1;
            note.ms  = lat_l1;
            note.gap = '0;
        end
    end

    assign plen   = pattern_len(act1[3:0]);
    assign pos2   = pos1 + POS_W'(1);
    assign dly_ms = ton1 ? note.gap : note.ms;
    assign dly_us = {10'd0, dly_ms} * 23'(US_PER_MS);
    assign dl_add = item.now_time + {25'd0, dly_us};

    // Per-opcode update
    always_comb begin
        nxt = cur;
        res = '0;
        unique case (item.opcode)
            OP_TICK: begin
                nxt.pending_mask = mask1;
                nxt.active_alert = act1;
                nxt.note_pos     = pos1;
                nxt.tone_on      = ton1;
                nxt.deadline     = dl1;
                nxt.lat_freq     = lat_f1;
                nxt.lat_len      = lat_l1;
                res.stop_cmd     = preempt && (cur.active_alert != NO_ALERT) && cur.tone_on;
                if ((act1 != NO_ALERT) && !(item.now_time < dl1)) begin
                    if (ton1) begin
                        // tone ends: gap, or pattern done and next pending starts
                        res.stop_cmd = 1'b1;
                        nxt.tone_on  = 1'b0;
                        nxt.note_pos = pos2;
                        if (pos2 >= plen) begin
                            nxt.active_alert = NO_ALERT;
                            if (top_pend != NO_ALERT) begin
                                nxt.pending_mask[top_pend[3:0]] = 1'b0;
                                nxt.active_alert = top_pend;
                                nxt.note_pos     = '0;
                                nxt.deadline     = item.now_time;
                                nxt.lat_freq     = cur.req_freq;
                                nxt.lat_len      = cur.req_len;
                            end
                        end else begin
                            nxt.deadline = dl_add;
                        end
                    end else if (pos1 >= plen) begin
                        nxt.active_alert = NO_ALERT;
                    end else begin
                        res.start_cmd = 1'b1;
                        res.tone_freq = note.hz;
                        res.tone_len  = note.ms;
                        nxt.tone_on   = 1'b1;
                        nxt.deadline  = dl_add;
                    end
                end
            end
            OP_NOTIFY: begin
                if (!item.alert_id[4]) begin
                    nxt.pending_mask[item.alert_id[3:0]] = 1'b1;
                end
            end
            OP_PLAY_CUSTOM: begin
                nxt.req_freq        = clamp_val(item.custom_freq, FREQ_MIN, FREQ_MAX);
                nxt.req_len         = clamp_val(item.custom_len, LEN_MIN, LEN_MAX);
                nxt.pending_mask[0] = 1'b1;
            end
            OP_STOP_CUSTOM: begin
                nxt.pending_mask[0] = 1'b0;
                if (cur.active_alert == ID_W'(0)) begin
                    res.stop_cmd     = cur.tone_on;
                    nxt.active_alert = NO_ALERT;
                    nxt.tone_on      = 1'b0;
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
        res.playing_alert = nxt.active_alert;
    end

endmodule

### hw/rtl/priority_tone_alert_sequencer_top.sv
`timescale 1ns / 1ps

// Buzzer alert sequencer. Each request (tick, notify, play custom, stop custom)
// gives exactly one result carrying stop/start tone commands and the alert
// now playing. A request is registered on entry, worked through the
// next-state logic, and lands in the result register, which drives m_tvalid,
// once that register is empty or m_tready is high (two register stages),
// and one request is taken every cycle while the result side keeps
// up. Throughput is set by the single registered pass; the 48-bit deadline
// add and compare form the longest path.
// There is no memory and no clearing pass; the note patterns are a constant table.
module priority_tone_alert_sequencer_top import ptas_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // alert_id[4:0], custom_freq[20:5], custom_len[36:21], now_time[84:37]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // stop_cmd[0], start_cmd[1], tone_freq[14:2], tone_len[27:15],
    // playing_alert[32:28]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    logic    advance;

    // Request moves from input register to result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ptas_step u_step (
        .cur  (state_reg),
        .item (in_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.opcode      <= s_tuser;
            in_reg.alert_id    <= s_tdata[4:0];
            in_reg.custom_freq <= s_tdata[20:5];
            in_reg.custom_len  <= s_tdata[36:21];
            in_reg.now_time    <= s_tdata[84:37];
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{active_alert: NO_ALERT, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.playing_alert, out_reg.tone_len, out_reg.tone_freq,
                       out_reg.start_cmd, out_reg.stop_cmd};

endmodule

### hw/rtl/ptas_checker.sv
`timescale 1ns / 1ps
`include "priority_tone_alert_sequencer_top_defines.svh"

// Port-level checks on the result stream
module ptas_checker import ptas_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    `PTAS_ASSERT(a_start_needs_alert, m_tvalid && m_tdata[1] |-> m_tdata[32:28] != NO_ALERT, "tone started with no alert playing")
    `PTAS_ASSERT(a_idle_tone_zero, m_tvalid && !m_tdata[1] |-> m_tdata[27:2] == 26'd0, "tone fields set without start")
    `PTAS_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `PTAS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid && s_tready, "pipeline not empty after reset")

endmodule

bind priority_tone_alert_sequencer_top ptas_checker u_ptas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
